/* rtl/core/bfrg_pkg.sv */
// ----------------------------------------------------------------------------
// bfrg_pkg
// Shared types, codes and constants of the five-byte float random generator.
// ----------------------------------------------------------------------------
package bfrg_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  seed_exponent;
    logic [30:0] seed_fraction;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  result_exponent;
    logic [30:0] result_fraction;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_RESEED  = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_BYTE,
    S_MUL_BIT,
    S_MUL_NORM,
    S_ADD_ALIGN,
    S_ADD_SUM,
    S_ADD_NORM,
    S_SCR_LOAD,
    S_SCR_NORM,
    S_SCR_ROUND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic mul_init;
    logic scr_seed;
    logic mul_skip;
    logic mul_bit;
    logic norm_step;
    logic add_align;
    logic add_sum;
    logic scr_load;
    logic scr_round;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic byte_last;
    logic bit_last;
    logic norm_done;
    logic sum_done;
    logic out_free;
  } sts_t;

  localparam logic [8:0]        MUL_EXP_ADJ = 9'd24;
  localparam logic [8:0]        EXP_MAX     = 9'd255;
  localparam logic [31:0]       MUL_MANT    = 32'hB544_7A00;
  localparam logic [7:0]        ADD_EXP     = 8'h68;
  localparam logic [31:0]       ADD_MANT    = 32'hA8B1_4600;
  localparam logic [8:0]        EXP_BIAS    = 9'd128;
  localparam logic signed [9:0] ALIGN_LIM   = 10'sd64;

endpackage

/* rtl/core/bfrg_ctrl.sv */
// ----------------------------------------------------------------------------
// bfrg_ctrl
// Sequencer: steps the datapath through multiply, add, scramble, round and output.
// ----------------------------------------------------------------------------
module bfrg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  output logic          in_stall,
  input  bfrg_pkg::sts_t sts,
  output bfrg_pkg::cmd_t cmd
);
  import bfrg_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_ADVANCE: state_nxt = S_MUL_BYTE;
            OP_RESEED:  state_nxt = S_SCR_NORM;
            OP_READ:    state_nxt = S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_MUL_BYTE: begin
        if (sts.byte_zero && !sts.byte_last) begin
          state_nxt = S_MUL_BYTE;
        end else begin
          state_nxt = S_MUL_BIT;
        end
      end
      S_MUL_BIT: begin
        if (sts.bit_last) begin
          state_nxt = sts.byte_last ? S_MUL_NORM : S_MUL_BYTE;
        end
      end
      S_MUL_NORM: begin
        if (sts.norm_done) begin
          state_nxt = S_ADD_ALIGN;
        end
      end
      S_ADD_ALIGN: state_nxt = S_ADD_SUM;
      S_ADD_SUM:   state_nxt = S_ADD_NORM;
      S_ADD_NORM: begin
        if (sts.sum_done) begin
          state_nxt = S_SCR_LOAD;
        end
      end
      S_SCR_LOAD: state_nxt = S_SCR_NORM;
      S_SCR_NORM: begin
        if (sts.norm_done) begin
          state_nxt = S_SCR_ROUND;
        end
      end
      S_SCR_ROUND: state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.mul_init = accept && (in_op == OP_ADVANCE);
        cmd.scr_seed = accept && (in_op == OP_RESEED);
      end
      S_MUL_BYTE: cmd.mul_skip  = sts.byte_zero && !sts.byte_last;
      S_MUL_BIT:  cmd.mul_bit   = 1'b1;
      S_MUL_NORM: cmd.norm_step = !sts.norm_done;
      S_ADD_ALIGN: cmd.add_align = 1'b1;
      S_ADD_SUM:  cmd.add_sum   = 1'b1;
      S_ADD_NORM: cmd.norm_step = !sts.sum_done;
      S_SCR_LOAD: cmd.scr_load  = 1'b1;
      S_SCR_NORM: cmd.norm_step = !sts.norm_done;
      S_SCR_ROUND: cmd.scr_round = 1'b1;
      S_DONE:     cmd.out_load  = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

/* rtl/core/bfrg_datapath.sv */
// ----------------------------------------------------------------------------
// bfrg_datapath
// Seed register, 40-bit accumulator, exponent and multiplier shift registers,
// output register.
// ----------------------------------------------------------------------------
module bfrg_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  bfrg_pkg::in_item_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output bfrg_pkg::out_item_t out_data,
  input  bfrg_pkg::cmd_t      cmd,
  output bfrg_pkg::sts_t      sts
);
  import bfrg_pkg::*;

  logic [7:0]  seed_exp_r, seed_exp_nxt;
  logic [30:0] seed_frac_r, seed_frac_nxt;
  logic [39:0] acc_r, acc_nxt;
  logic [39:0] addend_r, addend_nxt;
  logic [8:0]  exp_r, exp_nxt;
  logic [31:0] mplr_r, mplr_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [1:0]  byte_cnt_r, byte_cnt_nxt;
  logic        carry_r, carry_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic [8:0]        mul_exp_sum;
  logic [32:0]       mul_sum;
  logic [40:0]       mul_add;
  logic signed [9:0] diff;
  logic signed [9:0] neg_diff;
  logic [39:0]       m1;
  logic [39:0]       m2;
  logic [40:0]       sum;
  logic              sum_zero;
  logic [32:0]       rnd;
  logic [30:0]       seed_man_in;
  logic [30:0]       add_man;
  logic [7:0]        add_exp;

  function automatic logic [39:0] scramble_word(input logic [7:0] ex,
                                                input logic [30:0] man);
    logic [31:0] m;
    m = {1'b1, man};
    return {m[7:0], m[15:8], m[23:16], m[31:24], ex};
  endfunction

  assign mul_exp_sum = {1'b0, seed_exp_r} + MUL_EXP_ADJ;
  assign mul_sum     = {1'b0, acc_r[39:8]} + {1'b0, MUL_MANT};
  assign mul_add     = {mul_sum, acc_r[7:0]};
  assign diff        = $signed({2'b00, exp_r[7:0]}) - $signed({2'b00, ADD_EXP});
  assign neg_diff    = -diff;
  assign m1          = {1'b1, acc_r[38:0]};
  assign m2          = {ADD_MANT, 8'h00};
  assign sum         = {1'b0, acc_r} + {1'b0, addend_r};
  assign sum_zero    = (exp_r == '0) || exp_r[8] || (acc_r[39:8] == '0);
  assign add_man     = sum_zero ? '0 : acc_r[38:8];
  assign add_exp     = sum_zero ? '0 : exp_r[7:0];
  assign rnd         = {1'b0, acc_r[39:8]} + {32'd0, acc_r[7]};
  assign seed_man_in = (in_data.seed_exponent == '0) ? '0 : in_data.seed_fraction;

  always_comb begin
    seed_exp_nxt  = seed_exp_r;
    seed_frac_nxt = seed_frac_r;
    acc_nxt       = acc_r;
    addend_nxt    = addend_r;
    exp_nxt       = exp_r;
    mplr_nxt      = mplr_r;
    bit_cnt_nxt   = bit_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cmd.mul_init) begin
      if (seed_exp_r == '0) begin
        exp_nxt = '0;
      end else begin
        exp_nxt = (mul_exp_sum > EXP_MAX) ? EXP_MAX : mul_exp_sum;
      end
      acc_nxt      = '0;
      mplr_nxt     = {1'b1, seed_frac_r};
      bit_cnt_nxt  = '0;
      byte_cnt_nxt = '0;
      carry_nxt    = 1'b0;
    end

    if (cmd.mul_skip) begin
      acc_nxt      = carry_r ? (acc_r >> 8) : (acc_r >> 9);
      carry_nxt    = 1'b0;
      mplr_nxt     = mplr_r >> 8;
      byte_cnt_nxt = byte_cnt_r + 2'd1;
    end

    if (cmd.mul_bit) begin
      acc_nxt     = mplr_r[0] ? mul_add[40:1] : (acc_r >> 1);
      mplr_nxt    = mplr_r >> 1;
      bit_cnt_nxt = bit_cnt_r + 3'd1;
      if (bit_cnt_r == 3'd7) begin
        carry_nxt    = 1'b1;
        byte_cnt_nxt = byte_cnt_r + 2'd1;
      end
    end

    if (cmd.norm_step) begin
      acc_nxt = {acc_r[38:0], 1'b0};
      exp_nxt = exp_r - 9'd1;
    end

    if (cmd.add_align) begin
      if ((exp_r == '0) || (diff < -ALIGN_LIM)) begin
        acc_nxt    = m2;
        addend_nxt = '0;
        exp_nxt    = {1'b0, ADD_EXP};
      end else if (diff > ALIGN_LIM) begin
        acc_nxt    = m1;
        addend_nxt = '0;
      end else if (diff > 10'sd0) begin
        acc_nxt    = m1;
        addend_nxt = m2 >> diff[6:0];
      end else if (diff < 10'sd0) begin
        acc_nxt    = m1 >> neg_diff[6:0];
        addend_nxt = m2;
        exp_nxt    = {1'b0, ADD_EXP};
      end else begin
        acc_nxt    = m1;
        addend_nxt = m2;
      end
    end

    if (cmd.add_sum) begin
      if (sum[40]) begin
        acc_nxt = sum[40:1];
        exp_nxt = exp_r + 9'd1;
      end else begin
        acc_nxt = sum[39:0];
      end
    end

    if (cmd.scr_load) begin
      acc_nxt = scramble_word(add_exp, add_man);
      exp_nxt = EXP_BIAS;
    end

    if (cmd.scr_seed) begin
      acc_nxt = scramble_word(in_data.seed_exponent, seed_man_in);
      exp_nxt = EXP_BIAS;
    end

    if (cmd.scr_round) begin
      if (exp_r == '0) begin
        seed_exp_nxt  = '0;
        seed_frac_nxt = '0;
      end else if (rnd[32]) begin
        seed_exp_nxt  = exp_r[7:0] + 8'd1;
        seed_frac_nxt = '0;
      end else begin
        seed_exp_nxt  = exp_r[7:0];
        seed_frac_nxt = rnd[30:0];
      end
    end

    if (cmd.out_load) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.result_exponent = seed_exp_r;
      out_data_nxt.result_fraction = (seed_exp_r == '0) ? '0 : seed_frac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_exp_r  <= '0;
      seed_frac_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seed_exp_r  <= seed_exp_nxt;
      seed_frac_r <= seed_frac_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    addend_r   <= addend_nxt;
    exp_r      <= exp_nxt;
    mplr_r     <= mplr_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    byte_cnt_r <= byte_cnt_nxt;
    carry_r    <= carry_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.byte_zero = (mplr_r[7:0] == '0);
  assign sts.byte_last = (byte_cnt_r == 2'd3);
  assign sts.bit_last  = (bit_cnt_r == 3'd7);
  assign sts.norm_done = (exp_r == '0) || acc_r[39];
  assign sts.sum_done  = (exp_r == '0) || acc_r[39] || (acc_r[39:8] == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/basic_float_rnd_generator.sv */
// ----------------------------------------------------------------------------
// basic_float_rnd_generator
// Random generator on a five-byte binary float seed (advance, reseed, read).
// ----------------------------------------------------------------------------
// One item at a time: in_stall is high from the transfer of an item until its
// result is loaded into the output register, which then waits for the sink
// while the next item is taken; a result still waiting there holds the next
// one back for as long as the sink stalls. Read goes straight to the output
// load; reseed loads the scrambled seed, normalizes it (up to 24 shifts) and
// rounds it. Advance runs through a single 40-bit accumulator: after the
// transfer each multiplier byte is checked, a zero byte is skipped in one shift
// and a nonzero byte is added and shifted bit by bit; then come the product
// normalize, alignment, sum, sum normalize, scramble load, scramble normalize
// (up to 24 shifts), rounding and output load. The accumulator shifts one bit
// per cycle while multiplying a nonzero byte or normalizing.
module basic_float_rnd_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bfrg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bfrg_pkg::out_item_t out_data
);
  import bfrg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfrg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfrg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/core/bfrg_checker.sv */
// ----------------------------------------------------------------------------
// bfrg_checker
// Port-level checks of the random generator, bound to the top level.
// ----------------------------------------------------------------------------
module bfrg_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input bfrg_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input bfrg_pkg::out_item_t out_data
);
  import bfrg_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in flight");

  a_zero_fraction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_exponent == 8'd0) |-> (out_data.result_fraction == 31'd0))
    else $error("zero result with nonzero fraction");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind basic_float_rnd_generator bfrg_checker u_bfrg_checker (.*);
